// File: design/etb_pkg.sv
// shared types and constants for the elimination tree builder
// no dependencies; imported by every other design file
package etb_pkg;

    localparam int MAX_NODES = 1024;
    localparam int IDX_W     = 10;
    localparam int ENTRY_W   = IDX_W + 1;

    localparam logic CMD_ENTRY = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        logic cmd;
        t_idx row_index;
        t_idx col_index;
    } t_in_item;

    typedef struct packed {
        t_idx child_node;
        t_idx parent_node;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic clr_start;
        logic clr_step;
        logic rd_en;
        logic wr_anc;
        logic emit;
        logic step_next;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_is_clear;
        logic in_walks;
        logic clr_done;
        logic anc_valid;
        logic next_ok;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/etb_ctrl.sv
// controller state machine of the elimination tree builder
// depends on etb_pkg
module etb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  etb_pkg::t_dp_stat i_stat,
    output etb_pkg::t_dp_cmd  o_cmd
);
    import etb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_is_clear) begin
                        n_state = ST_CLEAR;
                    end else if (i_stat.in_walks) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!i_stat.anc_valid) begin
                    if (i_stat.out_free) n_state = ST_IDLE;
                end else if (i_stat.next_ok) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.clr_start = i_stat.in_is_clear;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_EVAL: begin
                if (!i_stat.anc_valid) begin
                    o_cmd.wr_anc = i_stat.out_free;
                    o_cmd.emit   = i_stat.out_free;
                end else begin
                    o_cmd.wr_anc    = 1'b1;
                    o_cmd.step_next = i_stat.next_ok;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: design/etb_dpath.sv
// datapath of the elimination tree builder: ancestor memory, walk registers,
// clearing counter and output register; depends on etb_pkg
module etb_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  etb_pkg::t_in_item  i_in,
    input  etb_pkg::t_dp_cmd   i_cmd,
    output etb_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output etb_pkg::t_out_item o_out
);
    import etb_pkg::*;

    t_entry    r_mem [MAX_NODES];
    t_entry    r_rd_data;
    t_idx      r_k;
    t_idx      r_cur;
    t_idx      r_clr_cnt;
    logic      r_out_valid;
    t_out_item r_out;

    logic   wr_en;
    t_idx   wr_addr;
    t_entry wr_data;
    t_idx   anc;

    assign anc = r_rd_data[IDX_W-1:0];

    // one write port shared by the clearing sweep and the walk
    always_comb begin
        wr_en   = i_cmd.clr_step | i_cmd.wr_anc;
        wr_addr = i_cmd.clr_step ? r_clr_cnt : r_cur;
        wr_data = i_cmd.clr_step ? '0 : {1'b1, r_k};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rd_data <= r_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_k   <= i_in.row_index;
            r_cur <= i_in.col_index;
        end else if (i_cmd.step_next) begin
            r_cur <= anc;
        end
        if (i_cmd.emit) begin
            r_out.child_node  <= r_cur;
            r_out.parent_node <= r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.in_is_clear = (i_in.cmd == CMD_CLEAR);
        o_stat.in_walks    = (i_in.col_index < i_in.row_index);
        o_stat.clr_done    = (r_clr_cnt == IDX_W'(MAX_NODES - 1));
        o_stat.anc_valid   = r_rd_data[ENTRY_W-1];
        o_stat.next_ok     = (anc > r_cur) && (anc < r_k);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: design/elimination_tree_builder_top.sv
// Elimination tree builder. Pattern entries (row k, column i) of a sparse
// symmetric matrix's lower triangle come in on the input channel in
// nondecreasing row order. An entry with i < k walks the ancestor chain from
// i, pointing every visited node at k, and when it meets a node with no
// ancestor yet it sends out (child = that node, parent = k). Entries with
// i >= k give nothing. A clear command (cmd = 1) empties the ancestor store
// before a new matrix. After reset, and after every clear command, the block
// sweeps its 1024-entry ancestor memory one entry a cycle, and it takes no
// transfer until the sweep is done. For each node on its walk a pattern
// entry takes a registered read of the ancestor memory, then the update and
// decision; a pattern entry that does not walk needs only its transfer. The
// result sits in an output register, so the next entry is taken while it
// waits; an entry that finds the output register still full waits at its
// last step.
// depends on etb_pkg, etb_ctrl and etb_dpath
module elimination_tree_builder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  etb_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output etb_pkg::t_out_item o_out
);
    import etb_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing of clear sweep and ancestor walk
    etb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // ancestor memory, walk registers and output register
    etb_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> dp_stat.out_free)
        else $error("result loaded over a pending transfer");

    // sweep and walk never write the memory in the same cycle
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.clr_step && dp_cmd.wr_anc))
        else $error("two writers on the ancestor memory");

    // a loaded result shows up on the output next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |=> o_out_valid)
        else $error("loaded result not presented");

    // no input transfer while the memory is being read or swept
    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(dp_cmd.rd_en || dp_cmd.clr_step || dp_cmd.wr_anc))
        else $error("input taken while busy");
`endif

endmodule
